// ----- sv/cce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

   // fixed-point formats
   localparam int COORD_WIDTH     = 16;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int T_WIDTH         = PARAM_FRAC_BITS + 1;
   localparam int T_PROD_WIDTH    = 2 * T_WIDTH;
   localparam int WGT_WIDTH       = T_WIDTH + 3;
   localparam int PROD_WIDTH      = COORD_WIDTH + WGT_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int POINT_WIDTH     = 3 * COORD_WIDTH;
   localparam int NUM_WEIGHTS     = 4;
   localparam int NUM_AXES        = 3;

   // register file
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_ADDR_WIDTH  = 6;
   localparam int CSR_IDX_LSB     = 3;
   localparam int CSR_IDX_WIDTH   = CSR_ADDR_WIDTH - CSR_IDX_LSB;

   // pipeline depth from accept to result register
   localparam int NUM_STAGES      = 7;
   localparam int BASIS_STAGES    = 4;

   localparam logic [T_WIDTH-1:0]      ONE_T  = T_WIDTH'(1) << PARAM_FRAC_BITS;
   localparam logic [T_PROD_WIDTH-1:0] HALF_T = T_PROD_WIDTH'(1) << (PARAM_FRAC_BITS - 1);

   typedef logic signed [WGT_WIDTH-1:0] weight_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_CURVE_MODE = 3'd0,
      REG_POINT_A    = 3'd1,
      REG_POINT_B    = 3'd2,
      REG_POINT_C    = 3'd3,
      REG_POINT_D    = 3'd4
   } cce_reg_type;

   typedef struct packed {
      logic [BASIS_STAGES-1:0] stage_en;
      logic                    bezier;
   } cce_basis_ctl_type;

endpackage

`default_nettype wire

// ----- sv/cce_basis.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cce_basis (
   input  wire logic                              clock,
   input  wire cce_pkg::cce_basis_ctl_type        ctl,
   input  wire logic [cce_pkg::T_WIDTH-1:0]       param_t,
   output cce_pkg::weight_type                    weight [cce_pkg::NUM_WEIGHTS]
);
   import cce_pkg::*;

   // round a nonnegative q.p product back to q.p
   function automatic logic [T_WIDTH-1:0] round_q(input logic [T_PROD_WIDTH-1:0] p);
      logic [T_PROD_WIDTH-1:0] s;
      s = p + HALF_T;
      return s[PARAM_FRAC_BITS +: T_WIDTH];
   endfunction

   function automatic weight_type widen(input logic [T_WIDTH-1:0] v);
      return $signed({{(WGT_WIDTH - T_WIDTH){1'b0}}, v});
   endfunction

   localparam weight_type ONE_W = $signed(WGT_WIDTH'(ONE_T));

   // stage 1: clamped parameter
   logic [T_WIDTH-1:0] t_s1_in, t_s1_ff;

   // stage 2: squares
   logic [T_WIDTH-1:0] u_s1;
   logic [T_WIDTH-1:0] t_s2_ff, u_s2_ff, sq_s2_in, sq_s2_ff, u2_s2_in, u2_s2_ff;

   // stage 3: cubic terms
   logic [T_WIDTH-1:0] t_s3_ff, sq_s3_ff;
   logic [T_WIDTH-1:0] cu_s3_in, cu_s3_ff, uc_s3_in, uc_s3_ff;
   logic [T_WIDTH-1:0] tu2_s3_in, tu2_s3_ff, squ_s3_in, squ_s3_ff;

   // stage 4: weights
   weight_type t_w, sq_w, cu_w, uc_w, tu2_w, squ_w;
   weight_type weight_in [NUM_WEIGHTS];
   weight_type weight_ff [NUM_WEIGHTS];

   always_comb begin
      t_s1_in = (param_t > ONE_T) ? ONE_T : param_t;
   end

   always_comb begin
      u_s1     = ONE_T - t_s1_ff;
      sq_s2_in = round_q(T_PROD_WIDTH'(t_s1_ff) * T_PROD_WIDTH'(t_s1_ff));
      u2_s2_in = round_q(T_PROD_WIDTH'(u_s1) * T_PROD_WIDTH'(u_s1));
   end

   always_comb begin
      cu_s3_in  = round_q(T_PROD_WIDTH'(sq_s2_ff) * T_PROD_WIDTH'(t_s2_ff));
      uc_s3_in  = round_q(T_PROD_WIDTH'(u2_s2_ff) * T_PROD_WIDTH'(u_s2_ff));
      tu2_s3_in = round_q(T_PROD_WIDTH'(t_s2_ff) * T_PROD_WIDTH'(u2_s2_ff));
      squ_s3_in = round_q(T_PROD_WIDTH'(sq_s2_ff) * T_PROD_WIDTH'(u_s2_ff));
   end

   always_comb begin
      t_w   = widen(t_s3_ff);
      sq_w  = widen(sq_s3_ff);
      cu_w  = widen(cu_s3_ff);
      uc_w  = widen(uc_s3_ff);
      tu2_w = widen(tu2_s3_ff);
      squ_w = widen(squ_s3_ff);
      if (ctl.bezier) begin
         weight_in[0] = uc_w;
         weight_in[1] = tu2_w + (tu2_w <<< 1);
         weight_in[2] = squ_w + (squ_w <<< 1);
         weight_in[3] = cu_w;
      end else begin
         weight_in[0] = (cu_w <<< 1) - (sq_w + (sq_w <<< 1)) + ONE_W;
         weight_in[1] = cu_w - (sq_w <<< 1) + t_w;
         weight_in[2] = cu_w - sq_w;
         weight_in[3] = (sq_w + (sq_w <<< 1)) - (cu_w <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.stage_en[0]) begin
         t_s1_ff <= t_s1_in;
      end
      if (ctl.stage_en[1]) begin
         t_s2_ff  <= t_s1_ff;
         u_s2_ff  <= u_s1;
         sq_s2_ff <= sq_s2_in;
         u2_s2_ff <= u2_s2_in;
      end
      if (ctl.stage_en[2]) begin
         t_s3_ff   <= t_s2_ff;
         sq_s3_ff  <= sq_s2_ff;
         cu_s3_ff  <= cu_s3_in;
         uc_s3_ff  <= uc_s3_in;
         tu2_s3_ff <= tu2_s3_in;
         squ_s3_ff <= squ_s3_in;
      end
      if (ctl.stage_en[3]) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

`default_nettype wire

// ----- sv/cubic_curve_point_evaluator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// throughput: one transaction per cycle while rsp_stall is low; seven register stages, each stage moves
// on whenever it is empty or the stage after it moves, so bubbles are squeezed out
// reset: synchronous; clears all stage valid bits, curve_mode and the control points
module cubic_curve_point_evaluator_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // parameter input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [cce_pkg::T_WIDTH-1:0]           req_param_t,
   // curve point output channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cce_pkg::COORD_WIDTH-1:0]     rsp_coord_x,
   output logic signed [cce_pkg::COORD_WIDTH-1:0]     rsp_coord_y,
   output logic signed [cce_pkg::COORD_WIDTH-1:0]     rsp_coord_z,
   output logic                                       rsp_clipped,
   // register port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [cce_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [cce_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [cce_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                                       csr_pready
);
   import cce_pkg::*;

   localparam logic signed [SUM_WIDTH-1:0] HALF_S  = SUM_WIDTH'(1) <<< (PARAM_FRAC_BITS - 1);
   localparam logic signed [SUM_WIDTH-1:0] CW_MAX  = (SUM_WIDTH'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam logic signed [SUM_WIDTH-1:0] CW_MIN  = -(SUM_WIDTH'(1) <<< (COORD_WIDTH - 1));

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic                     mode_ff;
   logic [POINT_WIDTH-1:0]   point_ff [NUM_WEIGHTS];
   logic                     csr_write;
   cce_reg_type              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // registers sit on 8-byte boundaries, low address bits are ignored
   assign csr_index  = cce_reg_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_IDX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            point_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_CURVE_MODE: mode_ff     <= csr_pwdata[0];
            REG_POINT_A:    point_ff[0] <= csr_pwdata[POINT_WIDTH-1:0];
            REG_POINT_B:    point_ff[1] <= csr_pwdata[POINT_WIDTH-1:0];
            REG_POINT_C:    point_ff[2] <= csr_pwdata[POINT_WIDTH-1:0];
            REG_POINT_D:    point_ff[3] <= csr_pwdata[POINT_WIDTH-1:0];
            default: ; // unmapped addresses drop the write
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CURVE_MODE: csr_prdata = CSR_DATA_WIDTH'(mode_ff);
         REG_POINT_A:    csr_prdata = CSR_DATA_WIDTH'(point_ff[0]);
         REG_POINT_B:    csr_prdata = CSR_DATA_WIDTH'(point_ff[1]);
         REG_POINT_C:    csr_prdata = CSR_DATA_WIDTH'(point_ff[2]);
         REG_POINT_D:    csr_prdata = CSR_DATA_WIDTH'(point_ff[3]);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // pipeline control
   // stage k loads when it is empty or stage k+1 loads; the last stage is the
   // output register, so the input keeps flowing while bubbles remain
   // ---------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in, go;
   cce_basis_ctl_type     basis_ctl;

   always_comb begin
      go[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (go[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !go[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   assign basis_ctl.stage_en = go[BASIS_STAGES-1:0];
   assign basis_ctl.bezier   = mode_ff;

   // ---------------------------------------------------------------------------
   // stages 1..4: clamp t, squares, cubes, basis weights
   // ---------------------------------------------------------------------------
   weight_type weight [NUM_WEIGHTS];

   cce_basis u_basis (
      .clock   (clock),
      .ctl     (basis_ctl),
      .param_t (req_param_t),
      .weight  (weight)
   );

   // ---------------------------------------------------------------------------
   // stage 5: one multiplier per control point and axis
   // ---------------------------------------------------------------------------
   logic signed [PROD_WIDTH-1:0] prod_in [NUM_AXES][NUM_WEIGHTS];
   logic signed [PROD_WIDTH-1:0] prod_ff [NUM_AXES][NUM_WEIGHTS];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int k = 0; k < NUM_WEIGHTS; k++) begin
            prod_in[a][k] = $signed(point_ff[k][a*COORD_WIDTH +: COORD_WIDTH]) * weight[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[4]) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 6: blend sum per axis
   // ---------------------------------------------------------------------------
   logic signed [SUM_WIDTH-1:0] sum_in [NUM_AXES];
   logic signed [SUM_WIDTH-1:0] sum_ff [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sum_in[a] = (SUM_WIDTH'(prod_ff[a][0]) + SUM_WIDTH'(prod_ff[a][1]))
                   + (SUM_WIDTH'(prod_ff[a][2]) + SUM_WIDTH'(prod_ff[a][3]));
      end
   end

   always_ff @(posedge clock) begin
      if (go[5]) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 7: round half up, saturate, output register
   // ---------------------------------------------------------------------------
   logic signed [SUM_WIDTH-1:0]   rounded [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] coord_in [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] coord_ff [NUM_AXES];
   logic [NUM_AXES-1:0]           sat;
   logic                          clipped_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         rounded[a] = (sum_ff[a] + HALF_S) >>> PARAM_FRAC_BITS;
         if (rounded[a] > CW_MAX) begin
            coord_in[a] = CW_MAX[COORD_WIDTH-1:0];
            sat[a]      = 1'b1;
         end else if (rounded[a] < CW_MIN) begin
            coord_in[a] = CW_MIN[COORD_WIDTH-1:0];
            sat[a]      = 1'b1;
         end else begin
            coord_in[a] = rounded[a][COORD_WIDTH-1:0];
            sat[a]      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[6]) begin
         coord_ff   <= coord_in;
         clipped_ff <= |sat;
      end
   end

   assign rsp_coord_x = coord_ff[0];
   assign rsp_coord_y = coord_ff[1];
   assign rsp_coord_z = coord_ff[2];
   assign rsp_clipped = clipped_ff;

endmodule

`default_nettype wire
